>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, quiet during reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/trm_pkg.sv
package trm_pkg;

  // field widths
  localparam int RAW_X_W = 11;
  localparam int RAW_Y_W = 10;
  localparam int PIX_W   = 16;
  localparam int CNT_W   = 2;
  localparam int RECT_CNT = 3;
  localparam int MASK_W  = RECT_CNT;
  localparam int ROT_W   = 2;
  localparam int AREA_W  = 2 * PIX_W;
  localparam int OUT_W   = 8;

  localparam int MAX_SCREENS_DEF = 3;

  // configuration port
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_LSB  = 3;
  localparam int ADDR_W    = REG_IDX_W + ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_PANEL_W  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_H  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RECT0    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RECT1    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RECT2    = 3'd7;

  localparam logic [PIX_W-1:0] PANEL_W_RST = 16'd1280;
  localparam logic [PIX_W-1:0] PANEL_H_RST = 16'd720;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // digitizer grid
  localparam int RAW_W = 1280;
  localparam int RAW_H = 720;

  // scaled point widths: raw * panel size
  localparam int SX_W = RAW_X_W + PIX_W;
  localparam int SY_W = RAW_Y_W + PIX_W;
  // bounds (x + w) * 1280 and (y + h) * 720
  localparam int BX_W = SX_W + 1;
  localparam int BY_W = SY_W + 1;

  // ix = nx / (5 w), iy = 4 ny / (15 h), ry = 16 ny / (45 h)
  localparam int X_DEN_MUL = 5;
  localparam int Y_NUM_MUL = 4;
  localparam int Y_DEN_MUL = 15;
  localparam int R_NUM_MUL = 16;
  localparam int R_DEN_MUL = 45;

  localparam int Q_W   = OUT_W;
  localparam int SH_W  = $clog2(Q_W);
  localparam int DIV_W = 22;
  localparam int NUM_W = DIV_W + Q_W;

  localparam logic [OUT_W-1:0] X_MAX = 8'd255;
  localparam logic [OUT_W-1:0] Y_MAX = 8'd191;

  typedef struct packed {
    logic [PIX_W-1:0] h;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] x;
  } rect_t;

  typedef struct packed {
    logic [PIX_W-1:0]                 pnl_wid;
    logic [PIX_W-1:0]                 pnl_hgt;
    logic [CNT_W-1:0]                 rect_limit;
    logic [MASK_W-1:0]                touch_enable_mask;
    logic [ROT_W-1:0]                 rotation;
    rect_t [RECT_CNT-1:0]             rects;
    logic [RECT_CNT-1:0][AREA_W-1:0]  area;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [Q_W-1:0]   quo;
  } div_lane_t;

  typedef struct packed {
    logic      hit;
    div_lane_t x;
    div_lane_t y;
  } div_item_t;

  // one restoring step, quotient bit shifted in at the bottom
  function automatic div_lane_t div_step(div_lane_t l, logic [SH_W-1:0] sh);
    div_lane_t        r;
    logic [NUM_W-1:0] trial;
    r = l;
    trial = NUM_W'(l.dvs) << sh;
    if (l.rem >= trial) begin
      r.rem = l.rem - trial;
      r.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> src/touch_region_mapper.sv
// touch_region_mapper: maps a raw digitizer point onto a 256x192 target screen.
// requests enter on in_valid/in_ready carrying raw_x and raw_y; results leave on
// out_valid/out_ready carrying hit, ds_x and ds_y, one result per request, in order.
// the APB port sets panel size, rectangle count, enable mask, rotation and up to
// three rectangles at byte address 8*index; write only while no request is in flight.
// the path from input to output runs through four select stages (scale multiply,
// containment compares, largest-area pick, offset and operand setup), eight
// restoring divider stages at one quotient bit each, and the output register.
// throughput is one request per cycle while out_ready stays high.
// a stalled out_ready holds the output register, and the per-stage ready chain lets
// empty stages behind it keep filling, so nothing is dropped or duplicated.
// reset clears all valid bits and loads panel 1280x720, no rectangles, rotation 0.
module touch_region_mapper #(
  parameter int MAX_SCREENS = trm_pkg::MAX_SCREENS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trm_pkg::ADDR_W-1:0]  paddr,
  input  logic [trm_pkg::DATA_W-1:0]  pwdata,
  output logic [trm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trm_pkg::RAW_X_W-1:0] raw_x,
  input  logic [trm_pkg::RAW_Y_W-1:0] raw_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [trm_pkg::OUT_W-1:0]   ds_x,
  output logic [trm_pkg::OUT_W-1:0]   ds_y
);

  `include "assert_macros.svh"

  localparam int NUM_CAND = (MAX_SCREENS < trm_pkg::RECT_CNT) ? MAX_SCREENS
                                                               : trm_pkg::RECT_CNT;

  trm_pkg::cfg_t      cfg;
  logic               sel_valid, sel_ready;
  trm_pkg::div_item_t sel_item;
  logic               div_valid, div_ready;
  trm_pkg::div_item_t div_item;
  logic               rot_wr;

  trm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trm_select #(
    .NUM_CAND (NUM_CAND)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_item  (sel_item)
  );

  trm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_item   (sel_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  trm_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .rotation  (cfg.rotation),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_item   (div_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .ds_x      (ds_x),
    .ds_y      (ds_y)
  );

  assign rot_wr = psel && penable && pwrite && pready &&
                  (paddr[trm_pkg::ADDR_W-1:trm_pkg::ADDR_LSB] == trm_pkg::REG_ROTATION);

  `CHK_SAME(a_miss_zero, out_valid && !hit, (ds_x == '0) && (ds_y == '0), "miss with coordinates")
  `CHK_SAME(a_y_range, out_valid, ds_y <= trm_pkg::Y_MAX, "ds_y beyond target height")
  `CHK_SAME(a_ready_chain, out_ready, in_ready, "pipeline blocked with sink ready")
  `CHK_NEXT(a_rot_write, rot_wr, cfg.rotation == $past(pwdata[trm_pkg::ROT_W-1:0]), "rotation write lost")

endmodule

>>> src/trm_regs.sv
module trm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trm_pkg::ADDR_W-1:0]    paddr,
  input  logic [trm_pkg::DATA_W-1:0]    pwdata,
  output logic [trm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output trm_pkg::cfg_t                 cfg
);

  logic [trm_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;
  trm_pkg::rect_t                wr_rect;
  logic [trm_pkg::AREA_W-1:0]    wr_area;

  assign idx     = paddr[trm_pkg::ADDR_W-1:trm_pkg::ADDR_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign wr_rect = trm_pkg::rect_t'(pwdata);
  // area kept beside each rectangle for the largest-area pick
  assign wr_area = trm_pkg::AREA_W'(wr_rect.w) * trm_pkg::AREA_W'(wr_rect.h);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pnl_wid           <= trm_pkg::PANEL_W_RST;
      cfg.pnl_hgt           <= trm_pkg::PANEL_H_RST;
      cfg.rect_limit        <= '0;
      cfg.touch_enable_mask <= '0;
      cfg.rotation          <= trm_pkg::ROT_0;
      cfg.rects             <= '0;
      cfg.area              <= '0;
    end else if (wr_en) begin
      unique case (idx)
        trm_pkg::REG_PANEL_W:  cfg.pnl_wid    <= pwdata[trm_pkg::PIX_W-1:0];
        trm_pkg::REG_PANEL_H:  cfg.pnl_hgt    <= pwdata[trm_pkg::PIX_W-1:0];
        trm_pkg::REG_COUNT:    cfg.rect_limit <= pwdata[trm_pkg::CNT_W-1:0];
        trm_pkg::REG_MASK:     cfg.touch_enable_mask <= pwdata[trm_pkg::MASK_W-1:0];
        trm_pkg::REG_ROTATION: cfg.rotation <= pwdata[trm_pkg::ROT_W-1:0];
        trm_pkg::REG_RECT0: begin
          cfg.rects[0] <= wr_rect;
          cfg.area[0]  <= wr_area;
        end
        trm_pkg::REG_RECT1: begin
          cfg.rects[1] <= wr_rect;
          cfg.area[1]  <= wr_area;
        end
        trm_pkg::REG_RECT2: begin
          cfg.rects[2] <= wr_rect;
          cfg.area[2]  <= wr_area;
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      trm_pkg::REG_PANEL_W:  prdata = trm_pkg::DATA_W'(cfg.pnl_wid);
      trm_pkg::REG_PANEL_H:  prdata = trm_pkg::DATA_W'(cfg.pnl_hgt);
      trm_pkg::REG_COUNT:    prdata = trm_pkg::DATA_W'(cfg.rect_limit);
      trm_pkg::REG_MASK:     prdata = trm_pkg::DATA_W'(cfg.touch_enable_mask);
      trm_pkg::REG_ROTATION: prdata = trm_pkg::DATA_W'(cfg.rotation);
      trm_pkg::REG_RECT0:    prdata = trm_pkg::DATA_W'(cfg.rects[0]);
      trm_pkg::REG_RECT1:    prdata = trm_pkg::DATA_W'(cfg.rects[1]);
      trm_pkg::REG_RECT2:    prdata = trm_pkg::DATA_W'(cfg.rects[2]);
    endcase
  end

endmodule

>>> src/trm_select.sv
module trm_select #(
  parameter int NUM_CAND = trm_pkg::MAX_SCREENS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  trm_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trm_pkg::RAW_X_W-1:0] raw_x,
  input  logic [trm_pkg::RAW_Y_W-1:0] raw_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output trm_pkg::div_item_t          out_item
);

  localparam int SX_W = trm_pkg::SX_W;
  localparam int SY_W = trm_pkg::SY_W;
  localparam int BX_W = trm_pkg::BX_W;
  localparam int BY_W = trm_pkg::BY_W;

  // stage a: scale to panel pixels
  logic            a_v, a_rdy;
  logic [SX_W-1:0] a_sx;
  logic [SY_W-1:0] a_sy;
  // stage b: containment per rectangle
  logic                b_v, b_rdy;
  logic [SX_W-1:0]     b_sx;
  logic [SY_W-1:0]     b_sy;
  logic [NUM_CAND-1:0] b_hit;
  logic [NUM_CAND-1:0] hit_vec;
  // stage c: largest-area pick
  logic            c_v, c_rdy;
  logic [SX_W-1:0] c_sx;
  logic [SY_W-1:0] c_sy;
  logic            c_found;
  trm_pkg::rect_t  c_rect;
  logic                       sel_found;
  logic [trm_pkg::AREA_W-1:0] sel_area;
  trm_pkg::rect_t             sel_rect;
  // stage d: offsets and divider operands
  logic               d_v, d_rdy;
  trm_pkg::div_item_t d_item;
  trm_pkg::div_item_t d_next;
  logic [SX_W-1:0]    nx;
  logic [SY_W-1:0]    ny;
  logic               rot_odd;

  assign d_rdy    = !d_v || out_ready;
  assign c_rdy    = !c_v || d_rdy;
  assign b_rdy    = !b_v || c_rdy;
  assign a_rdy    = !a_v || b_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= in_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (d_rdy) d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_sx <= SX_W'(raw_x) * SX_W'(cfg.pnl_wid);
      a_sy <= SY_W'(raw_y) * SY_W'(cfg.pnl_hgt);
    end
  end

  always_comb begin
    logic [BX_W-1:0] lo_x, hi_x;
    logic [BY_W-1:0] lo_y, hi_y;
    for (int i = 0; i < NUM_CAND; i++) begin
      lo_x = BX_W'(cfg.rects[i].x) * BX_W'(trm_pkg::RAW_W);
      hi_x = (BX_W'(cfg.rects[i].x) + BX_W'(cfg.rects[i].w)) * BX_W'(trm_pkg::RAW_W);
      lo_y = BY_W'(cfg.rects[i].y) * BY_W'(trm_pkg::RAW_H);
      hi_y = (BY_W'(cfg.rects[i].y) + BY_W'(cfg.rects[i].h)) * BY_W'(trm_pkg::RAW_H);
      // empty rectangles fail the half-open test by themselves
      hit_vec[i] = cfg.touch_enable_mask[i]
                   && (trm_pkg::CNT_W'(i) < cfg.rect_limit)
                   && (BX_W'(a_sx) >= lo_x) && (BX_W'(a_sx) < hi_x)
                   && (BY_W'(a_sy) >= lo_y) && (BY_W'(a_sy) < hi_y);
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v) begin
      b_sx  <= a_sx;
      b_sy  <= a_sy;
      b_hit <= hit_vec;
    end
  end

  // strict compare keeps the lowest index on equal areas
  always_comb begin
    sel_found = 1'b0;
    sel_area  = '0;
    sel_rect  = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (b_hit[i] && (!sel_found || cfg.area[i] > sel_area)) begin
        sel_found = 1'b1;
        sel_area  = cfg.area[i];
        sel_rect  = cfg.rects[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_v) begin
      c_sx    <= b_sx;
      c_sy    <= b_sy;
      c_found <= sel_found;
      c_rect  <= sel_rect;
    end
  end

  assign rot_odd = (cfg.rotation == trm_pkg::ROT_90) || (cfg.rotation == trm_pkg::ROT_270);
  assign nx = c_sx - SX_W'(c_rect.x) * SX_W'(trm_pkg::RAW_W);
  assign ny = c_sy - SY_W'(c_rect.y) * SY_W'(trm_pkg::RAW_H);

  always_comb begin
    d_next.hit   = c_found;
    d_next.x.rem = trm_pkg::NUM_W'(nx);
    d_next.x.dvs = trm_pkg::DIV_W'(c_rect.w) * trm_pkg::DIV_W'(trm_pkg::X_DEN_MUL);
    d_next.x.quo = '0;
    // second lane gives ry for quarter turns, iy otherwise
    if (rot_odd) begin
      d_next.y.rem = trm_pkg::NUM_W'(ny) * trm_pkg::NUM_W'(trm_pkg::R_NUM_MUL);
      d_next.y.dvs = trm_pkg::DIV_W'(c_rect.h) * trm_pkg::DIV_W'(trm_pkg::R_DEN_MUL);
    end else begin
      d_next.y.rem = trm_pkg::NUM_W'(ny) * trm_pkg::NUM_W'(trm_pkg::Y_NUM_MUL);
      d_next.y.dvs = trm_pkg::DIV_W'(c_rect.h) * trm_pkg::DIV_W'(trm_pkg::Y_DEN_MUL);
    end
    d_next.y.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (d_rdy && c_v) d_item <= d_next;
  end

  assign out_valid = d_v;
  assign out_item  = d_item;

endmodule

>>> src/trm_divider.sv
module trm_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  trm_pkg::div_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output trm_pkg::div_item_t out_item
);

  localparam int STEPS = trm_pkg::Q_W;

  trm_pkg::div_item_t stg   [STEPS];
  logic               stg_v [STEPS];
  logic [STEPS:0]     rdy;

  assign rdy[STEPS] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [trm_pkg::SH_W-1:0] SH = trm_pkg::SH_W'(STEPS - 1 - k);

    trm_pkg::div_item_t src;
    logic               src_v;

    if (k == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = stg[k-1];
      assign src_v = stg_v[k-1];
    end

    assign rdy[k] = !stg_v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_v[k] <= 1'b0;
      end else if (rdy[k]) begin
        stg_v[k] <= src_v;
      end
    end

    // msb first, both lanes in lockstep
    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        stg[k].hit <= src.hit;
        stg[k].x   <= trm_pkg::div_step(src.x, SH);
        stg[k].y   <= trm_pkg::div_step(src.y, SH);
      end
    end
  end

  assign out_valid = stg_v[STEPS-1];
  assign out_item  = stg[STEPS-1];

endmodule

>>> src/trm_rotate.sv
module trm_rotate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [trm_pkg::ROT_W-1:0] rotation,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  trm_pkg::div_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic [trm_pkg::OUT_W-1:0] ds_x,
  output logic [trm_pkg::OUT_W-1:0] ds_y
);

  localparam int W = trm_pkg::OUT_W;

  logic [W-1:0] ix, q2, ix34, nx_x, nx_y;
  logic [W+1:0] ix3;

  assign ix   = in_item.x.quo;
  assign q2   = in_item.y.quo;
  // ix * 192 / 256
  assign ix3  = {1'b0, ix, 1'b0} + (W+2)'(ix);
  assign ix34 = ix3[W+1:2];

  always_comb begin
    unique case (rotation)
      trm_pkg::ROT_0: begin
        nx_x = ix;
        nx_y = q2;
      end
      trm_pkg::ROT_90: begin
        nx_x = q2;
        nx_y = trm_pkg::Y_MAX - ix34;
      end
      trm_pkg::ROT_180: begin
        nx_x = trm_pkg::X_MAX - ix;
        nx_y = trm_pkg::Y_MAX - q2;
      end
      trm_pkg::ROT_270: begin
        nx_x = trm_pkg::X_MAX - q2;
        nx_y = ix34;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hit  <= in_item.hit;
      ds_x <= in_item.hit ? nx_x : '0;
      ds_y <= in_item.hit ? nx_y : '0;
    end
  end

endmodule
